// File: design/ucfd_pkg.sv
// Shared definitions for the unwind code slot decoder: slot layout, unwind
// operation codes, configuration register indexes and the slot-count decoder.
// No dependencies.
`timescale 1ns / 1ps

package ucfd_pkg;

    localparam int SLOT_W   = 16;
    localparam int OP_W     = 4;
    localparam int CNT_W    = 8;
    localparam int ACC_W    = 32;
    localparam int FRAME_W  = 64;
    localparam int OFFS_W   = 33;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [OP_W-1:0] op_t;

    // unwind operation codes
    localparam op_t OP_PUSH_NONVOL      = 4'd0;
    localparam op_t OP_ALLOC_LARGE      = 4'd1;
    localparam op_t OP_ALLOC_SMALL      = 4'd2;
    localparam op_t OP_SET_FPREG        = 4'd3;
    localparam op_t OP_SAVE_NONVOL      = 4'd4;
    localparam op_t OP_SAVE_NONVOL_FAR  = 4'd5;
    localparam op_t OP_EPILOG           = 4'd6;
    localparam op_t OP_SPARE            = 4'd7;
    localparam op_t OP_SAVE_XMM128      = 4'd8;
    localparam op_t OP_SAVE_XMM128_FAR  = 4'd9;
    localparam op_t OP_PUSH_MACHFRAME   = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_REG   = 2'd2;

    localparam logic [ACC_W-1:0] MACHFRAME_PLAIN = 32'h40;
    localparam logic [ACC_W-1:0] MACHFRAME_CODE  = 32'h48;
    localparam logic [ACC_W-1:0] PUSH_SIZE       = 32'd8;

    // number of slots an operation occupies, head included
    function automatic logic [1:0] op_slots(input op_t op, input op_t info);
        logic [1:0] n;
        n = 2'd1;
        unique case (op) inside
            OP_SAVE_NONVOL, OP_EPILOG, OP_SAVE_XMM128: n = 2'd2;
            OP_SAVE_NONVOL_FAR, OP_SPARE, OP_SAVE_XMM128_FAR: n = 2'd3;
            OP_ALLOC_LARGE: n = (info != 4'd0) ? 2'd3 : 2'd2;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

// File: design/unwind_code_frame_decoder_unit.sv
// A slot item enters the input register; a result it completes passes to the
// result register and m_valid. Throughput: one slot item per cycle while the
// result is not stalled; input register, step logic and result register form
// a 2-deep pipeline whose carried state (slot counter, held op, running totals)
// updates as each item advances. Reset (aresetn low, synchronous) clears all
// state, configuration and both valid flags; items are accepted once it ends.
// Top level of the unwind code slot decoder. Depends on ucfd_pkg.
`timescale 1ns / 1ps

module unwind_code_frame_decoder_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ucfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ucfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    // slot input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ucfd_pkg::SLOT_W-1:0]            s_slot_word,
    input  logic                                   s_begin_req,
    // results
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ucfd_pkg::OP_W-1:0]              m_op_code,
    output logic [ucfd_pkg::OP_W-1:0]              m_op_info,
    output logic [1:0]                             m_slots_used,
    output logic signed [ucfd_pkg::ACC_W-1:0]      m_stack_delta,
    output logic signed [ucfd_pkg::ACC_W-1:0]      m_frame_delta,
    output logic signed [ucfd_pkg::ACC_W-1:0]      m_stack_before,
    output logic [ucfd_pkg::FRAME_W-1:0]           m_frame_total,
    output logic                                   m_reg_saved_here,
    output logic signed [ucfd_pkg::OFFS_W-1:0]     m_saved_offset
);
    import ucfd_pkg::*;

    // configuration
    logic [CNT_W-1:0]   code_count_reg;
    logic [OP_W-1:0]    frame_offset_reg;
    logic [OP_W-1:0]    target_reg_reg;

    // input register
    logic               in_valid_reg;
    logic [SLOT_W-1:0]  in_word_reg;
    logic               in_begin_reg;

    // decoder state
    logic [CNT_W-1:0]   slot_index_reg, slot_index_next;
    logic [1:0]         slots_left_reg, slots_left_next;
    op_t                held_op_reg, held_op_next;
    op_t                held_info_reg, held_info_next;
    logic [SLOT_W-1:0]  held_low_reg, held_low_next;
    logic [ACC_W-1:0]   stack_total_reg, stack_total_next;
    logic [FRAME_W-1:0] frame_sum_reg, frame_sum_next;
    logic               reg_found_reg, reg_found_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    op_t                out_op_reg, out_info_reg;
    logic [1:0]         out_slots_reg;
    logic [ACC_W-1:0]   out_sd_reg, out_fd_reg, out_before_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_hit_reg;
    logic [OFFS_W-1:0]  out_off_reg;

    // step logic
    logic               advance;
    logic [CNT_W-1:0]   eff_index;
    logic [1:0]         eff_left;
    logic [ACC_W-1:0]   eff_stack;
    logic [FRAME_W-1:0] eff_frame;
    logic               eff_found;
    op_t                head_op, head_info;
    logic [1:0]         head_slots;
    logic               emit;
    op_t                em_op, em_info;
    logic [SLOT_W-1:0]  em_lo, em_hi;
    logic [ACC_W-1:0]   sd, fd;
    logic               hit;
    logic [OFFS_W-1:0]  off;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_count_reg   <= '0;
            frame_offset_reg <= '0;
            target_reg_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CODE_COUNT:   code_count_reg   <= cfg_data;
                CFG_FRAME_OFFSET: frame_offset_reg <= cfg_data[OP_W-1:0];
                CFG_TARGET_REG:   target_reg_reg   <= cfg_data[OP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_word_reg  <= s_slot_word;
            in_begin_reg <= s_begin_req;
        end
    end

    assign head_op    = in_word_reg[11:8];
    assign head_info  = in_word_reg[15:12];
    assign head_slots = op_slots(head_op, head_info);

    // a begin flag clears the carried state before the slot is taken
    always_comb begin
        eff_index = in_begin_reg ? '0 : slot_index_reg;
        eff_left  = in_begin_reg ? '0 : slots_left_reg;
        eff_stack = in_begin_reg ? '0 : stack_total_reg;
        eff_frame = in_begin_reg ? '0 : frame_sum_reg;
        eff_found = in_begin_reg ? 1'b0 : reg_found_reg;

        slot_index_next = eff_index;
        slots_left_next = eff_left;
        held_op_next    = in_begin_reg ? '0 : held_op_reg;
        held_info_next  = in_begin_reg ? '0 : held_info_reg;
        held_low_next   = in_begin_reg ? '0 : held_low_reg;
        emit    = 1'b0;
        em_op   = head_op;
        em_info = head_info;
        em_lo   = '0;
        em_hi   = '0;

        if (eff_index < code_count_reg) begin
            slot_index_next = eff_index + CNT_W'(eff_index != '1);
            if (eff_left == 2'd0) begin
                if (head_slots == 2'd1) begin
                    emit = 1'b1;
                end else begin
                    held_op_next    = head_op;
                    held_info_next  = head_info;
                    slots_left_next = head_slots - 2'd1;
                end
            end else if (eff_left == 2'd2) begin
                held_low_next   = in_word_reg;
                slots_left_next = 2'd1;
            end else begin
                slots_left_next = 2'd0;
                emit    = 1'b1;
                em_op   = held_op_reg;
                em_info = held_info_reg;
                if (op_slots(held_op_reg, held_info_reg) == 2'd3) begin
                    em_lo = held_low_reg;
                    em_hi = in_word_reg;
                end else begin
                    em_lo = in_word_reg;
                end
            end
        end
    end

    // deltas, saved-register hit and offset of the completed operation, and new totals
    always_comb begin
        case (em_op)
            OP_PUSH_NONVOL:    sd = PUSH_SIZE;
            OP_ALLOC_SMALL:    sd = {24'd0, ({1'b0, em_info} + 5'd1), 3'd0};
            OP_PUSH_MACHFRAME: sd = (em_info == '0) ? MACHFRAME_PLAIN : MACHFRAME_CODE;
            OP_ALLOC_LARGE:    sd = (em_info == '0) ? {13'd0, em_lo, 3'd0}
                                                    : {em_hi, 16'd0} + {16'd0, em_lo};
            default:           sd = '0;
        endcase
        fd = (em_op == OP_SET_FPREG) ? (ACC_W'(0) - {24'd0, frame_offset_reg, 4'd0}) : sd;

        hit = !eff_found && (em_info == target_reg_reg) &&
              (em_op == OP_PUSH_NONVOL || em_op == OP_SAVE_NONVOL ||
               em_op == OP_SAVE_NONVOL_FAR);
        off = '0;
        if (hit) begin
            case (em_op)
                OP_PUSH_NONVOL: off = {eff_stack[ACC_W-1], eff_stack};
                OP_SAVE_NONVOL: off = {14'd0, em_lo, 3'd0};
                default:        off = {1'b0, em_hi, em_lo};
            endcase
        end

        if (emit) begin
            stack_total_next = eff_stack + sd;
            frame_sum_next   = eff_frame + {{(FRAME_W-ACC_W){fd[ACC_W-1]}}, fd};
            reg_found_next   = eff_found || hit;
        end else begin
            stack_total_next = eff_stack;
            frame_sum_next   = eff_frame;
            reg_found_next   = eff_found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_index_reg  <= '0;
            slots_left_reg  <= '0;
            held_op_reg     <= '0;
            held_info_reg   <= '0;
            held_low_reg    <= '0;
            stack_total_reg <= '0;
            frame_sum_reg   <= '0;
            reg_found_reg   <= 1'b0;
        end else if (advance) begin
            slot_index_reg  <= slot_index_next;
            slots_left_reg  <= slots_left_next;
            held_op_reg     <= held_op_next;
            held_info_reg   <= held_info_next;
            held_low_reg    <= held_low_next;
            stack_total_reg <= stack_total_next;
            frame_sum_reg   <= frame_sum_next;
            reg_found_reg   <= reg_found_next;
        end
    end

    assign out_valid_next = (!out_valid_reg || m_ready) ? (advance && emit) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance && emit) begin
            out_op_reg     <= em_op;
            out_info_reg   <= em_info;
            out_slots_reg  <= op_slots(em_op, em_info);
            out_sd_reg     <= sd;
            out_fd_reg     <= fd;
            out_before_reg <= eff_stack;
            out_frame_reg  <= frame_sum_next;
            out_hit_reg    <= hit;
            out_off_reg    <= off;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_op_code        = out_op_reg;
    assign m_op_info        = out_info_reg;
    assign m_slots_used     = out_slots_reg;
    assign m_stack_delta    = out_sd_reg;
    assign m_frame_delta    = out_fd_reg;
    assign m_stack_before   = out_before_reg;
    assign m_frame_total    = out_frame_reg;
    assign m_reg_saved_here = out_hit_reg;
    assign m_saved_offset   = out_off_reg;

endmodule

// File: design/ucfd_checker.sv
// Port-level checks for the unwind code slot decoder, bound to its top level.
// Depends on ucfd_pkg and unwind_code_frame_decoder_unit.
`timescale 1ns / 1ps

module ucfd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [ucfd_pkg::OP_W-1:0]          m_op_code,
    input logic [1:0]                         m_slots_used,
    input logic signed [ucfd_pkg::ACC_W-1:0]  m_stack_delta,
    input logic signed [ucfd_pkg::ACC_W-1:0]  m_frame_delta,
    input logic                               m_reg_saved_here,
    input logic signed [ucfd_pkg::OFFS_W-1:0] m_saved_offset
);
    import ucfd_pkg::*;

    // no result item survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result item holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stack_delta) &&
        $stable(m_op_code) && $stable(m_saved_offset))
        else $error("stalled result item changed");

    a_slots_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_slots_used != 2'd0)
        else $error("result item with zero slots");

    // only set-frame-pointer splits frame delta from stack delta
    a_frame_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_op_code != OP_SET_FPREG |-> m_frame_delta == m_stack_delta)
        else $error("frame delta differs from stack delta");

    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_saved_here |-> m_saved_offset == '0)
        else $error("saved offset set without a hit");

endmodule

bind unwind_code_frame_decoder_unit ucfd_checker u_ucfd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_op_code        (m_op_code),
    .m_slots_used     (m_slots_used),
    .m_stack_delta    (m_stack_delta),
    .m_frame_delta    (m_frame_delta),
    .m_reg_saved_here (m_reg_saved_here),
    .m_saved_offset   (m_saved_offset)
);

// File: tb/sv/unwind_code_frame_decoder_unit_test.sv
// Self-checking testbench for unwind_code_frame_decoder_unit: directed slot table,
// then random unwind infos under several idle/stall mixes, checked by a built-in decoder.
// Depends on ucfd_pkg and the unwind_code_frame_decoder_unit RTL.
`timescale 1ns / 1ps

module unwind_code_frame_decoder_unit_test;

    import ucfd_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 10000;
    localparam int SLOT_TARGET = 1650;

    typedef struct packed {
        op_t         op_code;
        op_t         op_info;
        logic [1:0]  slots_used;
        logic [31:0] stack_delta;
        logic [31:0] frame_delta;
        logic [31:0] stack_before;
        logic [63:0] frame_total;
        logic        reg_saved_here;
        logic [32:0] saved_offset;
    } unwind_result_t;

    // per-item note: a typed row carries its own expected op (or none)
    typedef struct packed {
        logic           typed;
        logic           has_res;
        unwind_result_t res;
    } slot_note_t;

    typedef enum logic {ROW_SLOT, ROW_CFG} row_kind_t;

    // ROW_CFG packs {target, frame offset, code count} into word
    typedef struct packed {
        row_kind_t      kind;
        logic [15:0]    word;
        logic           beg;
        logic           typed;
        logic           has_res;
        unwind_result_t res;
    } directed_row_t;

    localparam unwind_result_t NO_RESULT = '0;
    localparam unwind_result_t ALLOC_SMALL_MAX = '{OP_ALLOC_SMALL, 4'hF, 2'd1, 32'h80, 32'h80,
        32'h0, 64'h80, 1'b0, 33'h0};
    localparam unwind_result_t FPREG_MAX_OFFSET = '{OP_SET_FPREG, 4'h0, 2'd1, 32'h0,
        32'hFFFF_FF10, 32'h80, 64'hFFFF_FFFF_FFFF_FF90, 1'b0, 33'h0};
    localparam unwind_result_t SAVE_FAR_HIT = '{OP_SAVE_NONVOL_FAR, 4'h5, 2'd3, 32'h0, 32'h0,
        32'h0, 64'h0, 1'b1, 33'h0_0012_5678};

    localparam directed_row_t DIRECTED_ROWS [30] = '{
        // code count still zero after reset: everything ignored
        '{ROW_SLOT, 16'h0000, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFFFF, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_CFG,  16'h3FFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hF200, 1'b1, 1'b1, 1'b1, ALLOC_SMALL_MAX},
        '{ROW_SLOT, 16'h0300, 1'b0, 1'b1, 1'b1, FPREG_MAX_OFFSET},
        // large alloc drives the stack total negative before the target push
        '{ROW_SLOT, 16'h1100, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h8000, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h3000, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0600, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0700, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h1111, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h2222, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0800, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0900, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFB00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  16'h5003, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h5500, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h5678, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0012, 1'b0, 1'b1, 1'b1, SAVE_FAR_HIT},
        // fourth slot with a count of three
        '{ROW_SLOT, 16'h0000, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h4500, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        // three-slot op fills the count exactly, next slot ignored; begin recovers
        '{ROW_SLOT, 16'h0100, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0005, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_SLOT, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RESULT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [SLOT_W-1:0]     s_slot_word;
    logic                  s_begin_req;
    logic                  m_valid;
    logic                  m_ready;
    logic [OP_W-1:0]       m_op_code;
    logic [OP_W-1:0]       m_op_info;
    logic [1:0]            m_slots_used;
    logic signed [31:0]    m_stack_delta;
    logic signed [31:0]    m_frame_delta;
    logic signed [31:0]    m_stack_before;
    logic [63:0]           m_frame_total;
    logic                  m_reg_saved_here;
    logic signed [32:0]    m_saved_offset;

    unwind_code_frame_decoder_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_slot_word     (s_slot_word),
        .s_begin_req     (s_begin_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_op_code       (m_op_code),
        .m_op_info       (m_op_info),
        .m_slots_used    (m_slots_used),
        .m_stack_delta   (m_stack_delta),
        .m_frame_delta   (m_frame_delta),
        .m_stack_before  (m_stack_before),
        .m_frame_total   (m_frame_total),
        .m_reg_saved_here(m_reg_saved_here),
        .m_saved_offset  (m_saved_offset)
    );

    // decoder state and register copies
    logic [7:0]  slot_pos    = '0;
    logic [1:0]  span_left   = '0;
    op_t         pend_op     = '0;
    op_t         pend_info   = '0;
    logic [15:0] pend_low    = '0;
    logic [31:0] stack_sum   = '0;
    logic [63:0] frame_acc   = '0;
    logic        target_seen = 1'b0;
    logic [7:0]  code_limit  = '0;
    logic [3:0]  fp_offset   = '0;
    logic [3:0]  watch_reg   = '0;

    unwind_result_t expected_ops[$];
    slot_note_t     note_q[$];

    int failures     = 0;
    int ops_checked  = 0;
    int slots_taken  = 0;
    int settings     = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    unwind_result_t predicted, observed, wanted;
    slot_note_t     note;
    logic           produced, taken;

    function automatic int slot_span(input op_t op, input op_t info);
        case (op)
            OP_ALLOC_LARGE:                                   return (info == 4'd0) ? 2 : 3;
            OP_SAVE_NONVOL, OP_EPILOG, OP_SAVE_XMM128:        return 2;
            OP_SAVE_NONVOL_FAR, OP_SPARE, OP_SAVE_XMM128_FAR: return 3;
            default:                                          return 1;
        endcase
    endfunction

    // Consumes one slot; returns 1 when it completes an op, with the op in r.
    function automatic logic decode_slot(input logic [15:0] word, input logic beg,
                                         output unwind_result_t r, output logic took);
        op_t         op;
        op_t         info;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        done;
        logic [31:0] sd;
        logic [31:0] fd;
        logic [31:0] prior;
        r = '0;
        took = 1'b0;
        done = 1'b0;
        op = '0;
        info = '0;
        lo = '0;
        hi = '0;
        if (beg) begin
            slot_pos = '0;
            span_left = '0;
            pend_op = '0;
            pend_info = '0;
            pend_low = '0;
            stack_sum = '0;
            frame_acc = '0;
            target_seen = 1'b0;
        end
        if (slot_pos >= code_limit)
            return 1'b0;
        took = 1'b1;
        if (slot_pos != 8'hFF)
            slot_pos++;
        if (span_left == 2'd0) begin
            op = word[11:8];
            info = word[15:12];
            if (slot_span(op, info) == 1) begin
                done = 1'b1;
            end else begin
                pend_op = op;
                pend_info = info;
                span_left = 2'(slot_span(op, info) - 1);
            end
        end else if (span_left == 2'd2) begin
            pend_low = word;
            span_left = 2'd1;
        end else begin
            span_left = 2'd0;
            op = pend_op;
            info = pend_info;
            done = 1'b1;
            if (slot_span(op, info) == 3) begin
                lo = pend_low;
                hi = word;
            end else begin
                lo = word;
            end
        end
        if (!done)
            return 1'b0;

        case (op)
            OP_PUSH_NONVOL:    sd = PUSH_SIZE;
            OP_ALLOC_SMALL:    sd = (32'(info) + 32'd1) << 3;
            OP_PUSH_MACHFRAME: sd = (info == 4'd0) ? MACHFRAME_PLAIN : MACHFRAME_CODE;
            OP_ALLOC_LARGE:    sd = (info == 4'd0) ? {13'b0, lo, 3'b0} : {hi, lo};
            default:           sd = '0;
        endcase
        fd = (op == OP_SET_FPREG) ? 32'd0 - {24'b0, fp_offset, 4'b0} : sd;
        prior = stack_sum;
        frame_acc += {{32{fd[31]}}, fd};

        r.op_code = op;
        r.op_info = info;
        r.slots_used = 2'(slot_span(op, info));
        r.stack_delta = sd;
        r.frame_delta = fd;
        r.stack_before = prior;
        r.frame_total = frame_acc;
        if (!target_seen && info == watch_reg) begin
            case (op)
                OP_PUSH_NONVOL: begin
                    r.reg_saved_here = 1'b1;
                    r.saved_offset = {prior[31], prior};
                end
                OP_SAVE_NONVOL: begin
                    r.reg_saved_here = 1'b1;
                    r.saved_offset = {14'b0, lo, 3'b0};
                end
                OP_SAVE_NONVOL_FAR: begin
                    r.reg_saved_here = 1'b1;
                    r.saved_offset = {1'b0, hi, lo};
                end
                default: ;
            endcase
            target_seen = r.reg_saved_here;
        end
        stack_sum = prior + sd;
        return 1'b1;
    endfunction

    function automatic string show_result(input unwind_result_t r);
        return $sformatf("op=%0d info=%0d n=%0d sd=%h fd=%h sb=%h ft=%h hit=%b off=%h",
                         r.op_code, r.op_info, r.slots_used, r.stack_delta, r.frame_delta,
                         r.stack_before, r.frame_total, r.reg_saved_here, r.saved_offset);
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // tracks register writes and accepted slots, checks results in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CODE_COUNT:   code_limit = cfg_data;
                    CFG_FRAME_OFFSET: fp_offset = cfg_data[3:0];
                    CFG_TARGET_REG:   watch_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                produced = decode_slot(s_slot_word, s_begin_req, predicted, taken);
                if (taken)
                    slots_taken++;
                note = note_q.pop_front();
                if (note.typed) begin
                    produced = note.has_res;
                    predicted = note.res;
                end
                if (produced)
                    expected_ops.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                observed = {m_op_code, m_op_info, m_slots_used, m_stack_delta, m_frame_delta,
                            m_stack_before, m_frame_total, m_reg_saved_here, m_saved_offset};
                if (expected_ops.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected op at %0t: %s", $time, show_result(observed));
                end else begin
                    wanted = expected_ops.pop_front();
                    ops_checked++;
                    if (observed !== wanted) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("op mismatch at %0t", $time);
                            $display("  expected %s", show_result(wanted));
                            $display("  actual   %s", show_result(observed));
                        end
                    end
                end
            end
        end
    end

    task automatic push_slot(input logic [15:0] word, input logic beg, input slot_note_t tag);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        note_q.push_back(tag);
        s_valid <= 1'b1;
        s_slot_word <= word;
        s_begin_req <= beg;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // stop sending, wait for every expected op, then cover the pipeline latency
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
            waited++;
        end while (expected_ops.size() != 0 && waited < DRAIN_LIMIT);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_registers(input logic [7:0] count, input logic [7:0] fpo,
                                  input logic [7:0] tgt);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CODE_COUNT;
        cfg_data <= count;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_index <= CFG_FRAME_OFFSET;
        cfg_data <= fpo;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_index <= CFG_TARGET_REG;
        cfg_data <= tgt;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // one unwind info: mostly well-formed ops, some noise and stray begins
    task automatic send_unwind_info(input int n_slots);
        logic [15:0] words[$];
        op_t         op;
        op_t         info;
        int          k;
        while (words.size() < n_slots) begin
            if ($urandom_range(99) < 8) begin
                words.push_back(16'($urandom));
            end else begin
                op = ($urandom_range(9) == 0) ? op_t'($urandom_range(11, 15))
                                              : op_t'($urandom_range(10));
                info = ($urandom_range(3) == 0) ? watch_reg : op_t'($urandom_range(15));
                words.push_back({info, op, 8'($urandom)});
                for (k = 1; k < slot_span(op, info); k++)
                    words.push_back(rand_operand());
            end
        end
        foreach (words[i])
            push_slot(words[i], i == 0 || $urandom_range(99) == 0, '0);
    endtask

    initial begin
        slot_note_t  tag;
        logic [7:0]  count;
        int          phase_no;
        int          infos;
        int          n;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_slot_word = '0;
        s_begin_req = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                load_registers(DIRECTED_ROWS[i].word[7:0], {4'h0, DIRECTED_ROWS[i].word[11:8]},
                               {4'h0, DIRECTED_ROWS[i].word[15:12]});
            end else begin
                tag.typed = DIRECTED_ROWS[i].typed;
                tag.has_res = DIRECTED_ROWS[i].has_res;
                tag.res = DIRECTED_ROWS[i].res;
                push_slot(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].beg, tag);
            end
        end

        phase_no = 0;
        while (slots_taken < SLOT_TARGET) begin
            // the hold-off phase needs a full count so results keep coming
            if (phase_no == 1 || phase_no == 4)
                count = 8'hFF;
            else if (phase_no == 2 || $urandom_range(19) == 0)
                count = 8'h00;
            else if ($urandom_range(19) == 0)
                count = 8'hFF;
            else
                count = 8'($urandom_range(1, 40));
            load_registers(count, ($urandom_range(3) == 0) ? 8'h0F : 8'($urandom),
                           8'($urandom));
            case (phase_no % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 49; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 49; end
                default: begin idle_pct = 9; stall_pct <= 9; end
            endcase
            // receiver holds off while the sender keeps offering, filling the block
            if (phase_no == 4)
                hold_asked <= hold_asked + 1;
            infos = (count > 8'd64) ? 1 : $urandom_range(2, 6);
            repeat (infos) begin
                if (count == 8'd0)
                    n = $urandom_range(1, 4);
                else if ($urandom_range(9) == 0)
                    n = $urandom_range(1, count);
                else
                    n = count + $urandom_range(0, 2);
                send_unwind_info(n);
            end
            phase_no++;
        end

        drain_results();
        $display("Decoded %0d slots into %0d checked ops across %0d register settings,",
                 slots_taken, ops_checked, settings);
        $display("under four idle/stall mixes and one %0d-cycle result hold-off.", LONG_HOLD);
        if (expected_ops.size() != 0) begin
            $display("%0d expected ops never arrived", expected_ops.size());
            failures += expected_ops.size();
        end
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/ucfd_pkg.sv
design/unwind_code_frame_decoder_unit.sv
design/ucfd_checker.sv
tb/sv/unwind_code_frame_decoder_unit_test.sv
